[sv/cooperative_task_scheduler_macros.svh]
// ----------------------------------------------------------------------------
// Cooperative task scheduler assertion macros
// Shared assertion forms for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef COOPERATIVE_TASK_SCHEDULER_MACROS_SVH
`define COOPERATIVE_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

[sv/cts_pkg.sv]
// ----------------------------------------------------------------------------
// Cooperative task scheduler package
// Sizes, command and record codes, and slot types shared by the RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W     = 6;

    localparam logic [IDX_W:0] SLOTS_LIMIT = (IDX_W + 1)'(NUM_SLOTS);

    // Input commands
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_ADD      = 2'd1;
    localparam logic [1:0] CMD_DEL      = 2'd2;
    localparam logic [1:0] CMD_DISPATCH = 2'd3;

    // Result record kinds
    localparam logic [2:0] KIND_TICK = 3'd0;
    localparam logic [2:0] KIND_ADD  = 3'd1;
    localparam logic [2:0] KIND_DEL  = 3'd2;
    localparam logic [2:0] KIND_RUN  = 3'd3;
    localparam logic [2:0] KIND_DONE = 3'd4;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
    } t_slot;

    typedef struct packed {
        logic dispatch;    // 0: age the slot, 1: take one pending run
    } t_alu_ctrl;

    typedef struct packed {
        logic fire;        // a run is taken from this slot
        logic drop;        // one-shot slot retires after its run
    } t_alu_flags;

endpackage

`default_nettype wire

[sv/cts_slot_alu.sv]
// ----------------------------------------------------------------------------
// Scheduler slot update unit
// Shared unit that ages one slot on a tick or takes one run on a dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_slot_alu (
    input  cts_pkg::t_alu_ctrl  i_ctrl,
    input  cts_pkg::t_slot      i_slot,
    output cts_pkg::t_slot      o_slot,
    output cts_pkg::t_alu_flags o_flags
);
    import cts_pkg::*;

    always_comb begin
        o_slot        = i_slot;
        o_flags.fire  = 1'b0;
        o_flags.drop  = 1'b0;
        if (i_ctrl.dispatch) begin
            // take one pending run, retire one-shot slots
            if (i_slot.pending != 8'd0) begin
                o_flags.fire   = 1'b1;
                o_flags.drop   = (i_slot.period == 16'd0);
                o_slot.pending = i_slot.pending - 8'd1;
            end
        end else begin
            if (i_slot.delay == 16'd0) begin
                // queue a run, saturate the count, reload periodic slots
                if (i_slot.pending != 8'hFF) begin
                    o_slot.pending = i_slot.pending + 8'd1;
                end
                if (i_slot.period != 16'd0) begin
                    o_slot.delay = i_slot.period;
                end
            end else begin
                o_slot.delay = i_slot.delay - 16'd1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/cooperative_task_scheduler.sv]
// Records: a tick or dispatch walks all 32 slots, then emits its closing record;
// an add stops at the lowest free slot (or errors when full) and a delete walks no
// slots; the record then sits in the output word. One input word is taken at a time.
// Slots go one per cycle through the shared update unit, save dispatch run stalls.
// Reset (synchronous, active low) clears the slot valid bits, the sequencer and the
// output valid; slot contents are left as they are and there is no clearing pass.
// ----------------------------------------------------------------------------
// Cooperative task scheduler
// Time-triggered slot table with tick, add, delete and dispatch commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cooperative_task_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input words
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: task_tag[7:0], start_delay[23:8], repeat_period[39:24],
    //        slot_index[45:40], zero pad[47:46]
    input  wire logic [47:0] i_s_axis_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    // Result words
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: slot_out[5:0], tag_out[13:6], error_flag[14], zero pad[15]
    output logic [15:0]      o_m_axis_tdata,
    // tuser: record_kind[2:0]
    output logic [2:0]       o_m_axis_tuser,
    // tlast: last
    output logic             o_m_axis_tlast
);
    import cts_pkg::*;

    `include "cooperative_task_scheduler_macros.svh"

    // Sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic r_state, n_state;
    logic [CNT_W-1:0] r_ptr, n_ptr;

    // Latched command word
    logic [1:0]       r_cmd;
    logic [7:0]       r_tag;
    logic [15:0]      r_dly;
    logic [15:0]      r_per;
    logic [IDX_W-1:0] r_idx;

    // Slot table: valid bits reset, contents written before they are read
    logic [NUM_SLOTS-1:0] r_valid;
    t_slot                r_slot [NUM_SLOTS];

    // Output word register
    logic             r_ov;
    logic [2:0]       r_kind;
    logic [IDX_W-1:0] r_oslot;
    logic [7:0]       r_otag;
    logic             r_oerr;
    logic             r_olast;

    logic              out_free;
    logic              at_end;
    logic [SLOT_W-1:0] ptr_idx;
    logic              cur_valid;
    t_slot             cur_slot;
    logic              idx_bad;
    logic              s_accept;

    t_alu_ctrl  alu_ctrl;
    t_slot      alu_slot;
    t_alu_flags alu_flags;

    // Emitted record and table write controls
    logic              emit;
    logic [2:0]        e_kind;
    logic [IDX_W-1:0]  e_slot;
    logic [7:0]        e_tag;
    logic              e_err;
    logic              e_last;
    logic              slot_we;
    t_slot             slot_wdata;
    logic              valid_set;
    logic              valid_clr;
    logic [SLOT_W-1:0] clr_idx;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // The output word can be loaded when empty or being taken this cycle
    assign out_free = !r_ov || i_m_axis_tready;
    assign at_end   = (r_ptr == CNT_W'(NUM_SLOTS));
    assign ptr_idx  = r_ptr[SLOT_W-1:0];
    assign cur_valid = r_valid[ptr_idx];
    assign cur_slot  = r_slot[ptr_idx];
    assign idx_bad   = ({1'b0, r_idx} >= SLOTS_LIMIT);

    assign alu_ctrl.dispatch = (r_cmd == CMD_DISPATCH);

    cts_slot_alu u_alu (
        .i_ctrl  (alu_ctrl),
        .i_slot  (cur_slot),
        .o_slot  (alu_slot),
        .o_flags (alu_flags)
    );

    // Sequencer: one slot per cycle, stall whenever a record cannot be placed
    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        emit       = 1'b0;
        e_kind     = KIND_TICK;
        e_slot     = '0;
        e_tag      = '0;
        e_err      = 1'b0;
        e_last     = 1'b0;
        slot_we    = 1'b0;
        slot_wdata = alu_slot;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        clr_idx    = ptr_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_WALK;
                    n_ptr   = '0;
                end
            end
            ST_WALK: begin
                unique case (r_cmd)
                    CMD_TICK: begin
                        if (at_end) begin
                            if (out_free) begin
                                emit    = 1'b1;
                                e_kind  = KIND_TICK;
                                e_last  = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end else begin
                            // age the slot only if it holds a task
                            slot_we = cur_valid;
                            n_ptr   = r_ptr + CNT_W'(1);
                        end
                    end
                    CMD_ADD: begin
                        if (at_end) begin
                            // table full
                            if (out_free) begin
                                emit    = 1'b1;
                                e_kind  = KIND_ADD;
                                e_err   = 1'b1;
                                e_last  = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end else if (!cur_valid) begin
                            if (out_free) begin
                                slot_we    = 1'b1;
                                slot_wdata = '{tag: r_tag, delay: r_dly,
                                               period: r_per, pending: 8'd0};
                                valid_set  = 1'b1;
                                emit       = 1'b1;
                                e_kind     = KIND_ADD;
                                e_slot     = IDX_W'(ptr_idx);
                                e_last     = 1'b1;
                                n_state    = ST_IDLE;
                            end
                        end else begin
                            n_ptr = r_ptr + CNT_W'(1);
                        end
                    end
                    CMD_DEL: begin
                        if (out_free) begin
                            valid_clr = !idx_bad;
                            clr_idx   = r_idx[SLOT_W-1:0];
                            emit      = 1'b1;
                            e_kind    = KIND_DEL;
                            e_slot    = r_idx;
                            e_err     = idx_bad;
                            e_last    = 1'b1;
                            n_state   = ST_IDLE;
                        end
                    end
                    CMD_DISPATCH: begin
                        if (at_end) begin
                            if (out_free) begin
                                emit    = 1'b1;
                                e_kind  = KIND_DONE;
                                e_last  = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end else if (cur_valid && alu_flags.fire) begin
                            // hold the pointer until the run record has a place
                            if (out_free) begin
                                slot_we   = 1'b1;
                                valid_clr = alu_flags.drop;
                                emit      = 1'b1;
                                e_kind    = KIND_RUN;
                                e_slot    = IDX_W'(ptr_idx);
                                e_tag     = cur_slot.tag;
                                n_ptr     = r_ptr + CNT_W'(1);
                            end
                        end else begin
                            n_ptr = r_ptr + CNT_W'(1);
                        end
                    end
                endcase
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr   <= '0;
            r_valid <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            if (valid_set) begin
                r_valid[ptr_idx] <= 1'b1;
            end
            if (valid_clr) begin
                r_valid[clr_idx] <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd <= i_s_axis_tuser;
            r_tag <= i_s_axis_tdata[7:0];
            r_dly <= i_s_axis_tdata[23:8];
            r_per <= i_s_axis_tdata[39:24];
            r_idx <= i_s_axis_tdata[45:40];
        end
        if (slot_we) begin
            r_slot[ptr_idx] <= slot_wdata;
        end
        if (emit) begin
            r_kind  <= e_kind;
            r_oslot <= e_slot;
            r_otag  <= e_tag;
            r_oerr  <= e_err;
            r_olast <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {1'b0, r_oerr, r_otag, r_oslot};
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tlast  = r_olast;

    // Checks
    `CTS_ASSERT_NOW(a_ptr_range, i_clk, i_rst_n, 1'b1, r_ptr <= CNT_W'(NUM_SLOTS))
    `CTS_ASSERT_NEXT(a_accept_walk, i_clk, i_rst_n, s_accept, (r_state == ST_WALK) && (r_ptr == '0))
    `CTS_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, emit && e_last, r_state == ST_IDLE)
    `CTS_ASSERT_NOW(a_run_not_last, i_clk, i_rst_n, r_ov && (r_kind == KIND_RUN), !r_olast)

endmodule

`default_nettype wire
